// File: rtl/core/polynomial_trajectory_eval_assert.svh
// assertion macros used by the trajectory evaluator checker
`ifndef POLYNOMIAL_TRAJECTORY_EVAL_ASSERT_SVH
`define POLYNOMIAL_TRAJECTORY_EVAL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pte_pkg.sv
// shared types, constants and helpers of the trajectory evaluator
`default_nettype none

package pte_pkg;

  localparam int NumLanes = 4;
  localparam int NumSteps = 6;
  localparam int NumCoefs = 6;
  localparam int TimeW    = 22;
  localparam int DataW    = 48;
  localparam int WgtW     = 54;
  localparam int SumW     = 56;
  localparam int HalfW    = 24;
  localparam int ProdW    = HalfW + TimeW;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 3;

  // lane order: value and its first three derivatives
  localparam int LanePos = 0;
  localparam int LaneVel = 1;
  localparam int LaneAcc = 2;
  localparam int LaneJrk = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgCoefConst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefLinear = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefSquare = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCoefCube   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCoefFourth = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCoefFifth  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDegreeMode = 3'd6;

  typedef logic signed [DataW-1:0] q48_t;
  typedef logic signed [WgtW-1:0]  wgt_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [TimeW-1:0]        time_t;
  typedef logic [ProdW-1:0]        prod_t;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic  valid;
    time_t t;
  } stage_ctl_t;

  // clamp a wide sum to the signed 48-bit range
  function automatic q48_t sat48(input sum_t x);
    sum_t max_v;
    sum_t min_v;
    max_v = {{(SumW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
    min_v = {{(SumW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
    if (x > max_v) begin
      return max_v[DataW-1:0];
    end else if (x < min_v) begin
      return min_v[DataW-1:0];
    end
    return x[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pte_weights.sv
// coefficient registers and the per-step derivative weight table
`default_nettype none

module pte_weights (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pte_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pte_pkg::DataW-1:0]    cfg_data_i,
  output pte_pkg::wgt_t                wgt_o [pte_pkg::NumSteps][pte_pkg::NumLanes]
);
  import pte_pkg::*;

  q48_t coef_q [NumCoefs];
  logic mode_q;
  wgt_t wgt_d  [NumSteps][NumLanes];
  wgt_t wgt_q  [NumSteps][NumLanes];
  wgt_t c0, c1, c2, c3, c4, c5;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoefs; i++) begin
        coef_q[i] <= '0;
      end
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        [CfgCoefConst:CfgCoefFifth]: coef_q[cfg_idx_i] <= q48_t'(cfg_data_i);
        CfgDegreeMode:               mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sign-extended coefficients, fifth one zero in quartic mode
  assign c0 = wgt_t'(coef_q[CfgCoefConst]);
  assign c1 = wgt_t'(coef_q[CfgCoefLinear]);
  assign c2 = wgt_t'(coef_q[CfgCoefSquare]);
  assign c3 = wgt_t'(coef_q[CfgCoefCube]);
  assign c4 = wgt_t'(coef_q[CfgCoefFourth]);
  assign c5 = mode_q ? wgt_t'(coef_q[CfgCoefFifth]) : '0;

  // horner weights per step, lower-order chains padded with leading zeros
  always_comb begin
    for (int s = 0; s < NumSteps; s++) begin
      for (int l = 0; l < NumLanes; l++) begin
        wgt_d[s][l] = '0;
      end
    end
    wgt_d[0][LanePos] = c5;
    wgt_d[1][LanePos] = c4;
    wgt_d[1][LaneVel] = c5 * wgt_t'(5);
    wgt_d[2][LanePos] = c3;
    wgt_d[2][LaneVel] = c4 * wgt_t'(4);
    wgt_d[2][LaneAcc] = c5 * wgt_t'(20);
    wgt_d[3][LanePos] = c2;
    wgt_d[3][LaneVel] = c3 * wgt_t'(3);
    wgt_d[3][LaneAcc] = c4 * wgt_t'(12);
    wgt_d[3][LaneJrk] = c5 * wgt_t'(60);
    wgt_d[4][LanePos] = c1;
    wgt_d[4][LaneVel] = c2 * wgt_t'(2);
    wgt_d[4][LaneAcc] = c3 * wgt_t'(6);
    wgt_d[4][LaneJrk] = c4 * wgt_t'(24);
    wgt_d[5][LanePos] = c0;
    wgt_d[5][LaneVel] = c1;
    wgt_d[5][LaneAcc] = c2 * wgt_t'(2);
    wgt_d[5][LaneJrk] = c3 * wgt_t'(6);
  end

  // weight table register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSteps; s++) begin
        for (int l = 0; l < NumLanes; l++) begin
          wgt_q[s][l] <= '0;
        end
      end
    end else begin
      wgt_q <= wgt_d;
    end
  end

  assign wgt_o = wgt_q;

endmodule

`default_nettype wire

// File: rtl/core/pte_step.sv
// one horner step over four lanes: multiply stage then round, add, saturate stage
`default_nettype none

module pte_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pte_pkg::stage_ctl_t ctl_i,
  input  pte_pkg::q48_t       acc_i [pte_pkg::NumLanes],
  input  pte_pkg::wgt_t       w_i   [pte_pkg::NumLanes],
  output pte_pkg::stage_ctl_t ctl_o,
  output pte_pkg::q48_t       acc_o [pte_pkg::NumLanes]
);
  import pte_pkg::*;

  logic [DataW-1:0] mag       [NumLanes];
  prod_t            hi_d      [NumLanes];
  prod_t            lo_d      [NumLanes];
  stage_ctl_t       ctl_a_q;
  logic             neg_a_q   [NumLanes];
  prod_t            hi_a_q    [NumLanes];
  prod_t            lo_a_q    [NumLanes];
  logic [WgtW-1:0]  scaled    [NumLanes];
  logic [ProdW:0]   lo_rnd    [NumLanes];
  sum_t             sum_d     [NumLanes];
  q48_t             acc_d     [NumLanes];
  stage_ctl_t       ctl_b_q;
  q48_t             acc_b_q   [NumLanes];

  // magnitude split in two halves, each times t
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      mag[l]  = acc_i[l][DataW-1] ? DataW'(-acc_i[l]) : DataW'(acc_i[l]);
      hi_d[l] = ProdW'(mag[l][DataW-1:HalfW]) * ProdW'(ctl_i.t);
      lo_d[l] = ProdW'(mag[l][HalfW-1:0]) * ProdW'(ctl_i.t);
    end
  end

  // multiply stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
    end
  end

  // multiply stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        neg_a_q[l] <= acc_i[l][DataW-1];
        hi_a_q[l]  <= hi_d[l];
        lo_a_q[l]  <= lo_d[l];
      end
    end
  end

  // recombine with rounding, restore sign, add weight, saturate
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      lo_rnd[l] = (ProdW+1)'(lo_a_q[l]) + (ProdW+1)'(1 << (FracW-1));
      scaled[l] = {hi_a_q[l], {(HalfW-FracW){1'b0}}}
                + WgtW'(lo_rnd[l][ProdW:FracW]);
      if (neg_a_q[l]) begin
        sum_d[l] = sum_t'(w_i[l]) - sum_t'({2'b00, scaled[l]});
      end else begin
        sum_d[l] = sum_t'(w_i[l]) + sum_t'({2'b00, scaled[l]});
      end
      acc_d[l] = sat48(sum_d[l]);
    end
  end

  // add stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_b_q <= ctl_a_q;
    end
  end

  // add stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        acc_b_q[l] <= acc_d[l];
      end
    end
  end

  assign ctl_o = ctl_b_q;
  assign acc_o = acc_b_q;

endmodule

`default_nettype wire

// File: rtl/core/polynomial_trajectory_eval.sv
// an accepted item passes the input capture register, the seed register and five
// horner steps of two stages each over four lanes; one item per cycle unless stalled
// a stall at the output freezes the whole pipe, nothing is dropped or repeated
// reset clears all valid bits, zeroes the coefficients and selects quintic mode
// the weight table is registered from the coefficient registers written by the port
// top level: configuration, input capture, horner step pipeline, output
`default_nettype none

module polynomial_trajectory_eval (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pte_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pte_pkg::DataW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pte_pkg::TimeW-1:0]   sample_time_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [pte_pkg::DataW-1:0] position_out_o,
  output logic signed [pte_pkg::DataW-1:0] velocity_out_o,
  output logic signed [pte_pkg::DataW-1:0] accel_out_o,
  output logic signed [pte_pkg::DataW-1:0] jerk_out_o
);
  import pte_pkg::*;

  logic       en;
  wgt_t       wgt   [NumSteps][NumLanes];
  stage_ctl_t ctl_in_q;
  stage_ctl_t ctl_s [NumSteps];
  q48_t       acc_s [NumSteps][NumLanes];

  // whole pipe advances unless the output item is held
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  pte_weights u_weights (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .wgt_o     (wgt)
  );

  // input capture and chain seed control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_in_q <= '0;
      ctl_s[0] <= '0;
    end else if (en) begin
      ctl_in_q.valid <= in_valid_i;
      ctl_in_q.t     <= sample_time_i;
      ctl_s[0]       <= ctl_in_q;
    end
  end

  // chain seed payload, seed is the leading weight
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NumLanes; l++) begin
        acc_s[0][l] <= wgt[0][l][DataW-1:0];
      end
    end
  end

  // horner steps
  for (genvar k = 1; k < NumSteps; k++) begin : g_step
    pte_step u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl_s[k-1]),
      .acc_i (acc_s[k-1]),
      .w_i   (wgt[k]),
      .ctl_o (ctl_s[k]),
      .acc_o (acc_s[k])
    );
  end

  // last step register is the output register
  assign out_valid_o    = ctl_s[NumSteps-1].valid;
  assign position_out_o = acc_s[NumSteps-1][LanePos];
  assign velocity_out_o = acc_s[NumSteps-1][LaneVel];
  assign accel_out_o    = acc_s[NumSteps-1][LaneAcc];
  assign jerk_out_o     = acc_s[NumSteps-1][LaneJrk];

endmodule

`default_nettype wire

// File: rtl/core/pte_checker.sv
// port-level checker for the trajectory evaluator and its bind
`default_nettype none

`include "polynomial_trajectory_eval_assert.svh"

module pte_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_ready_o,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic signed [pte_pkg::DataW-1:0] position_out_o,
  input  logic signed [pte_pkg::DataW-1:0] velocity_out_o,
  input  logic signed [pte_pkg::DataW-1:0] accel_out_o,
  input  logic signed [pte_pkg::DataW-1:0] jerk_out_o
);

  // a held output item stays valid
  `PTE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output item dropped while stalled")

  // a held output item keeps its payload
  `PTE_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(position_out_o) && $stable(velocity_out_o) && $stable(accel_out_o) && $stable(jerk_out_o), "output payload changed while stalled")

  // an empty output slot never blocks the input
  `PTE_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o, "input blocked with empty output")

  // a new output item only shows up after the pipe advanced
  `PTE_ASSERT_IMPL(a_rise_after_move, $rose(out_valid_o), $past(in_ready_o), "output item appeared while pipe was frozen")

endmodule

bind polynomial_trajectory_eval pte_checker u_pte_checker (.*);

`default_nettype wire

// File: tb/tb_polynomial_trajectory_eval.sv
// testbench for the trajectory polynomial evaluator: directed and random items, self-checking
module tb_polynomial_trajectory_eval;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pte_pkg::CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  localparam logic [pte_pkg::DataW-1:0] Q48Max = 48'h7FFF_FFFF_FFFF;
  localparam logic [pte_pkg::DataW-1:0] Q48Min = 48'h8000_0000_0000;
  localparam longint SatHigh = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatLow = -SatHigh - 1;
  localparam pte_pkg::time_t TimeMax = 22'h3F_FFFF;
  localparam int DrainCycles = 20;
  localparam int WatchdogLimit = 4000;
  localparam int RandomPhases = 14;
  localparam int ItemsPerPhase = 125;

  // expected trajectory sample, the time is kept for reports only
  typedef struct packed {
    pte_pkg::time_t t;
    logic [pte_pkg::DataW-1:0] position;
    logic [pte_pkg::DataW-1:0] velocity;
    logic [pte_pkg::DataW-1:0] accel;
    logic [pte_pkg::DataW-1:0] jerk;
  } trajectory_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pte_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [pte_pkg::DataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [pte_pkg::TimeW-1:0] sample_time_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [pte_pkg::DataW-1:0] position_out_o;
  logic signed [pte_pkg::DataW-1:0] velocity_out_o;
  logic signed [pte_pkg::DataW-1:0] accel_out_o;
  logic signed [pte_pkg::DataW-1:0] jerk_out_o;

  // shadow copy of the coefficient registers
  longint coef_shadow [pte_pkg::NumCoefs];
  logic quintic_shadow;

  pte_pkg::time_t pending_times[$];
  trajectory_t expected_trajectories[$];
  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit steady_flow;
  int send_wait;
  int recv_wait;

  polynomial_trajectory_eval dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_time_i  (sample_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_out_o (position_out_o),
    .velocity_out_o (velocity_out_o),
    .accel_out_o    (accel_out_o),
    .jerk_out_o     (jerk_out_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // one horner step: acc * t / 2^16 rounded half away from zero, plus weight, clamped
  function automatic longint horner_step(longint acc, longint weight, pte_pkg::time_t t);
    logic [71:0] mag;
    logic [71:0] scaled;
    longint sum;
    mag = (acc < 0) ? 72'(-acc) : 72'(acc);
    scaled = (mag * 72'(t) + 72'h8000) >> pte_pkg::FracW;
    sum = (acc < 0) ? weight - longint'(scaled[63:0]) : weight + longint'(scaled[63:0]);
    if (sum > SatHigh) begin
      return SatHigh;
    end
    if (sum < SatLow) begin
      return SatLow;
    end
    return sum;
  endfunction

  // position and derivatives at t; leading zero weights leave the chain at zero
  function automatic trajectory_t predict_trajectory(pte_pkg::time_t t);
    longint c5;
    longint wgt [pte_pkg::NumLanes][pte_pkg::NumSteps];
    longint acc;
    logic [pte_pkg::DataW-1:0] lane_val [pte_pkg::NumLanes];
    trajectory_t res;
    c5 = quintic_shadow ? coef_shadow[5] : 64'sd0;
    wgt[pte_pkg::LanePos][0] = c5;
    wgt[pte_pkg::LanePos][1] = coef_shadow[4];
    wgt[pte_pkg::LanePos][2] = coef_shadow[3];
    wgt[pte_pkg::LanePos][3] = coef_shadow[2];
    wgt[pte_pkg::LanePos][4] = coef_shadow[1];
    wgt[pte_pkg::LanePos][5] = coef_shadow[0];
    wgt[pte_pkg::LaneVel][0] = 0;
    wgt[pte_pkg::LaneVel][1] = 5 * c5;
    wgt[pte_pkg::LaneVel][2] = 4 * coef_shadow[4];
    wgt[pte_pkg::LaneVel][3] = 3 * coef_shadow[3];
    wgt[pte_pkg::LaneVel][4] = 2 * coef_shadow[2];
    wgt[pte_pkg::LaneVel][5] = coef_shadow[1];
    wgt[pte_pkg::LaneAcc][0] = 0;
    wgt[pte_pkg::LaneAcc][1] = 0;
    wgt[pte_pkg::LaneAcc][2] = 20 * c5;
    wgt[pte_pkg::LaneAcc][3] = 12 * coef_shadow[4];
    wgt[pte_pkg::LaneAcc][4] = 6 * coef_shadow[3];
    wgt[pte_pkg::LaneAcc][5] = 2 * coef_shadow[2];
    wgt[pte_pkg::LaneJrk][0] = 0;
    wgt[pte_pkg::LaneJrk][1] = 0;
    wgt[pte_pkg::LaneJrk][2] = 0;
    wgt[pte_pkg::LaneJrk][3] = 60 * c5;
    wgt[pte_pkg::LaneJrk][4] = 24 * coef_shadow[4];
    wgt[pte_pkg::LaneJrk][5] = 6 * coef_shadow[3];
    for (int lane = 0; lane < pte_pkg::NumLanes; lane++) begin
      acc = 0;
      for (int k = 0; k < pte_pkg::NumSteps; k++) begin
        acc = horner_step(acc, wgt[lane][k], t);
      end
      lane_val[lane] = acc[pte_pkg::DataW-1:0];
    end
    res.t = t;
    res.position = lane_val[pte_pkg::LanePos];
    res.velocity = lane_val[pte_pkg::LaneVel];
    res.accel = lane_val[pte_pkg::LaneAcc];
    res.jerk = lane_val[pte_pkg::LaneJrk];
    return res;
  endfunction

  function automatic void check_field(string name, pte_pkg::time_t t,
                                      logic [pte_pkg::DataW-1:0] want,
                                      logic [pte_pkg::DataW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch %s at t=%h: expected %h got %h", name, t, want, got);
      end
    end
  endfunction

  // coefficient: mostly moderate magnitudes, some full range, some limits
  function automatic logic [pte_pkg::DataW-1:0] rand_coef();
    logic [63:0] raw;
    int bits;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return raw[pte_pkg::DataW-1:0];
      2, 3: begin
        case ($urandom_range(0, 4))
          0: return Q48Max;
          1: return Q48Min;
          2: return '0;
          3: return 48'd1;
          default: return '1;
        endcase
      end
      default: begin
        bits = $urandom_range(2, 46);
        raw = raw & ((64'd1 << bits) - 64'd1);
        return ($urandom_range(0, 1) == 1) ? -raw[pte_pkg::DataW-1:0] : raw[pte_pkg::DataW-1:0];
      end
    endcase
  endfunction

  // time sample: short horizons most often, full range and corner values too
  function automatic pte_pkg::time_t rand_time();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 22'd1;
          2: return 22'h00_8000;
          3: return 22'h01_0000;
          default: return TimeMax;
        endcase
      end
      2, 3, 4: return pte_pkg::time_t'($urandom);
      default: return pte_pkg::time_t'($urandom_range(0, 262143));
    endcase
  endfunction

  // register write, then a wait before returning so the weight table follows the write
  task automatic write_register(logic [pte_pkg::CfgIdxW-1:0] idx,
                                logic [pte_pkg::DataW-1:0] data);
    pte_pkg::q48_t value;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    value = data;
    if (idx < pte_pkg::CfgDegreeMode) begin
      coef_shadow[idx] = value;
    end else if (idx == pte_pkg::CfgDegreeMode) begin
      quintic_shadow = data[0];
    end
    @(posedge clk_i);
  endtask

  task automatic issue_time(pte_pkg::time_t t);
    pending_times.push_back(t);
    items_queued++;
  endtask

  // wait until every item is through, then let the pipe run empty
  task automatic settle();
    while (items_accepted != items_queued || expected_trajectories.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_time_i <= '0;
      send_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_trajectories.push_back(predict_trajectory(sample_time_i));
        items_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_times.size() != 0) begin
          sample_time_i <= pending_times.pop_front();
          in_valid_i <= 1'b1;
          send_wait = steady_flow ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_trajectories.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: %h %h %h %h", position_out_o, velocity_out_o,
                     accel_out_o, jerk_out_o);
          end
        end else begin
          trajectory_t want;
          want = expected_trajectories.pop_front();
          check_field("position", want.t, want.position, position_out_o);
          check_field("velocity", want.t, want.velocity, velocity_out_o);
          check_field("accel", want.t, want.accel, accel_out_o);
          check_field("jerk", want.t, want.jerk, jerk_out_o);
        end
        recv_wait = steady_flow ? 0 : $urandom_range(0, 9);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake or write
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL polynomial_trajectory_eval");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < pte_pkg::NumCoefs; k++) begin
      coef_shadow[k] = 0;
    end
    quintic_shadow = 1'b1;
    items_queued = 0;
    items_accepted = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    steady_flow = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero coefficients give zero everywhere
    issue_time('0);
    issue_time(TimeMax);
    settle();

    // all coefficients at the positive limit, intermediate sums clamp
    for (int k = 0; k < pte_pkg::NumCoefs; k++) begin
      write_register(pte_pkg::CfgCoefConst + 3'(k), Q48Max);
    end
    write_register(pte_pkg::CfgDegreeMode, '1);
    issue_time('0);
    issue_time(22'd1);
    issue_time(22'h01_0000);
    issue_time(TimeMax);
    settle();

    // negative limit in quartic mode, junk in the unused mode bits
    for (int k = 0; k < pte_pkg::NumCoefs; k++) begin
      write_register(pte_pkg::CfgCoefConst + 3'(k), Q48Min);
    end
    write_register(pte_pkg::CfgDegreeMode, 48'hFFFF_FFFF_FFFE);
    issue_time('0);
    issue_time(22'h00_8000);
    issue_time(TimeMax);
    settle();

    // tiny coefficients of both signs: rounding ties at half a unit
    write_register(pte_pkg::CfgCoefConst, -48'sd9);
    write_register(pte_pkg::CfgCoefLinear, 48'sd7);
    write_register(pte_pkg::CfgCoefSquare, -48'sd5);
    write_register(pte_pkg::CfgCoefCube, 48'sd3);
    write_register(pte_pkg::CfgCoefFourth, -48'sd1);
    write_register(pte_pkg::CfgCoefFifth, 48'sd1);
    write_register(pte_pkg::CfgDegreeMode, 48'd1);
    issue_time(22'h00_8000);
    issue_time(22'h01_8000);
    issue_time(22'h2A_AAAA);
    issue_time(22'h15_5555);
    issue_time(22'h00_4000);
    issue_time(22'h00_C000);
    settle();

    // write to the spare index must change nothing
    write_register(CfgIdxSpare, '1);
    issue_time(22'h00_8000);
    issue_time(TimeMax);
    settle();

    // random coefficient sets, some phases at full rate
    for (int phase = 0; phase < RandomPhases; phase++) begin
      steady_flow = (phase % 4 == 3);
      for (int k = 0; k < pte_pkg::NumCoefs; k++) begin
        write_register(pte_pkg::CfgCoefConst + 3'(k), rand_coef());
      end
      write_register(pte_pkg::CfgDegreeMode, 48'({$urandom, $urandom}));
      repeat (ItemsPerPhase) issue_time(rand_time());
      settle();
    end

    if (mismatch_count == 0 && expected_trajectories.size() == 0) begin
      $display("PASS polynomial_trajectory_eval");
    end else begin
      $display("FAIL polynomial_trajectory_eval");
    end
    $finish;
  end

endmodule
